>>> hdl/lfu_pkg.sv
// lfu_pkg: command and status types shared by the lfu cache controller and datapath
// no dependencies

package lfu_pkg;

    localparam logic [4:0] LIMIT_RESET = 5'd10;
    localparam int         FREQ_W      = 16;
    localparam int         SLOT_W      = 4;

    // one-hot commands from the controller, at most one high per cycle
    typedef struct packed {
        logic load;    // capture the request
        logic lookup;  // tag compare, hit update or insert into a free slot
        logic scan;    // one step of the least-count search
        logic evict;   // overwrite the least-count entry
        logic finish;  // load the result registers
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic has_free;
        logic scan_last;
    } t_status;

endpackage

>>> hdl/lfu_ctrl.sv
// lfu_ctrl: sequencing state machine of the lfu cache
// depends on lfu_pkg for the command and status structs

module lfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lfu_pkg::t_status i_status,
    output lfu_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_SCAN   = 5'b00100,
        S_EVICT  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_status.hit || i_status.has_free) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT:  n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_start;
    assign o_cmd.lookup  = (r_state == S_LOOKUP);
    assign o_cmd.scan    = (r_state == S_SCAN);
    assign o_cmd.evict   = (r_state == S_EVICT);
    assign o_cmd.finish  = (r_state == S_FINISH);

endmodule

>>> hdl/lfu_dp.sv
// lfu_dp: tag array, use counts, payload memory, occupancy and result registers
// depends on lfu_pkg; driven by lfu_ctrl through t_cmd / t_status

module lfu_dp #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lfu_pkg::t_cmd    i_cmd,
    output lfu_pkg::t_status o_status,
    input  logic             i_cfg_wr_en,
    input  logic [4:0]       i_cfg_wr_data,
    input  logic [31:0]      i_key,
    input  logic [31:0]      i_value,
    output logic             o_valid,
    output logic             o_hit,
    output logic [15:0]      o_frequency,
    output logic [31:0]      o_value_out,
    output logic [3:0]       o_slot,
    output logic             o_evicted,
    output logic [31:0]      o_evicted_key,
    output logic [15:0]      o_evicted_frequency
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (OW > 5) ? OW : 5;
    localparam logic [IW-1:0]         LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

    // control state
    logic [4:0]             r_limit;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [OW-1:0]          r_occ;
    logic                   r_out_valid;

    // entry storage
    logic [31:0]           r_tag [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt [MAX_ENTRIES];
    logic [31:0]           mem_payload [MAX_ENTRIES];
    logic [31:0]           r_mem_rdata;

    // request and working registers
    logic [31:0]           r_key;
    logic [31:0]           r_value;
    logic                  r_hit;
    logic [IW-1:0]         r_slot;
    logic                  r_evict;
    logic [31:0]           r_ev_key;
    logic [15:0]           r_ev_freq;
    logic [IW-1:0]         r_scan_idx;
    logic                  r_found;
    logic [COUNT_BITS-1:0] r_best;
    logic [IW-1:0]         r_best_idx;

    // result registers
    logic        r_o_hit;
    logic [15:0] r_o_freq;
    logic [31:0] r_o_value;
    logic [3:0]  r_o_slot;
    logic        r_o_evicted;
    logic [31:0] r_o_ev_key;
    logic [15:0] r_o_ev_freq;

    logic [MAX_ENTRIES-1:0] c_match;
    logic                   c_hit;
    logic [IW-1:0]          c_hit_idx;
    logic [IW-1:0]          c_free_idx;
    logic [LW-1:0]          c_limit;
    logic                   c_has_free;
    logic [IW-1:0]          c_rd_idx;
    logic [COUNT_BITS-1:0]  c_rd_cnt;
    logic [IW-1:0]          c_ev_idx;

    // parallel tag compare and lowest-index encoders
    always_comb begin
        c_hit_idx  = '0;
        c_free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            c_match[i] = r_valid[i] && (r_tag[i] == r_key);
            if (c_match[i]) begin
                c_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                c_free_idx = IW'(i);
            end
        end
        c_hit = |c_match;
    end

    // limit clamped to 1..MAX_ENTRIES
    always_comb begin
        c_limit = LW'(r_limit);
        if (r_limit == 5'd0) begin
            c_limit = LW'(1);
        end
        if (c_limit > LW'(MAX_ENTRIES)) begin
            c_limit = LW'(MAX_ENTRIES);
        end
    end

    assign c_has_free = (LW'(r_occ) < c_limit);
    assign c_ev_idx   = r_found ? r_best_idx : '0;

    // single count read port, address by phase
    always_comb begin
        priority if (i_cmd.lookup) begin
            c_rd_idx = c_hit_idx;
        end else if (i_cmd.scan) begin
            c_rd_idx = r_scan_idx;
        end else if (i_cmd.evict) begin
            c_rd_idx = c_ev_idx;
        end else begin
            c_rd_idx = r_slot;
        end
    end
    assign c_rd_cnt = r_cnt[c_rd_idx];

    assign o_status.hit       = c_hit;
    assign o_status.has_free  = c_has_free;
    assign o_status.scan_last = (r_scan_idx == LAST_IDX);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= lfu_pkg::LIMIT_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.finish;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (i_cmd.lookup && !c_hit && c_has_free) begin
                r_valid[c_free_idx] <= 1'b1;
                r_occ               <= r_occ + OW'(1);
            end
            // only when no valid entry was found during the scan
            if (i_cmd.evict && !r_valid[c_ev_idx]) begin
                r_valid[c_ev_idx] <= 1'b1;
                r_occ             <= r_occ + OW'(1);
            end
        end
    end

    // entry and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.lookup) begin
            r_hit      <= c_hit;
            r_evict    <= 1'b0;
            r_ev_key   <= '0;
            r_ev_freq  <= '0;
            r_scan_idx <= '0;
            r_found    <= 1'b0;
            if (c_hit) begin
                r_slot <= c_hit_idx;
                if (c_rd_cnt != CNT_MAX) begin
                    r_cnt[c_hit_idx] <= c_rd_cnt + CNT_ONE;
                end
            end else if (c_has_free) begin
                r_slot             <= c_free_idx;
                r_tag[c_free_idx]  <= r_key;
                r_cnt[c_free_idx]  <= CNT_ONE;
            end
        end
        if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + IW'(1);
            // strict less-than keeps the lowest index on a tie
            if (r_valid[r_scan_idx] && (!r_found || c_rd_cnt < r_best)) begin
                r_found    <= 1'b1;
                r_best     <= c_rd_cnt;
                r_best_idx <= r_scan_idx;
            end
        end
        if (i_cmd.evict) begin
            r_slot          <= c_ev_idx;
            r_evict         <= r_found;
            r_ev_key        <= r_found ? r_tag[c_ev_idx] : 32'd0;
            r_ev_freq       <= r_found ? 16'(c_rd_cnt) : 16'd0;
            r_tag[c_ev_idx] <= r_key;
            r_cnt[c_ev_idx] <= CNT_ONE;
        end
    end

    // payload memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup && !c_hit && c_has_free) begin
            mem_payload[c_free_idx] <= r_value;
        end else if (i_cmd.evict) begin
            mem_payload[c_ev_idx] <= r_value;
        end
        r_mem_rdata <= mem_payload[c_hit_idx];
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_hit     <= r_hit;
            r_o_freq    <= r_hit ? 16'(c_rd_cnt) : 16'd1;
            r_o_value   <= r_hit ? r_mem_rdata : r_value;
            r_o_slot    <= 4'(r_slot);
            r_o_evicted <= r_evict;
            r_o_ev_key  <= r_ev_key;
            r_o_ev_freq <= r_ev_freq;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_hit               = r_o_hit;
    assign o_frequency         = r_o_freq;
    assign o_value_out         = r_o_value;
    assign o_slot              = r_o_slot;
    assign o_evicted           = r_o_evicted;
    assign o_evicted_key       = r_o_ev_key;
    assign o_evicted_frequency = r_o_ev_freq;

endmodule

>>> hdl/lfu_cache_policy.sv
// lfu_cache_policy: top level of the least-frequently-used cache
// depends on lfu_pkg, lfu_ctrl and lfu_dp
//
// channel   direction  handshake                 payload
// request   in         start & !busy             i_key, i_value
// result    out        o_valid (one cycle)       o_hit, o_frequency, o_value_out, o_slot,
//                                                o_evicted, o_evicted_key, o_evicted_frequency
// config    in         i_cfg_wr_en               i_cfg_wr_data (entries_in_use)
//
// busy stays high through lookup and finish for a hit or an insert into a free slot; the result
// strobes in the first cycle with busy low, when the next request may already be taken.
// a miss with a full table runs a least-count scan, one entry per cycle over the
// count array, and then runs the evict and finish states.
// synchronous active-low reset clears valid bits and occupancy; no clearing pass.
// results cannot be held off by the receiver.

module lfu_cache_policy #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    output logic        o_valid,
    output logic        o_hit,
    output logic [15:0] o_frequency,
    output logic [31:0] o_value_out,
    output logic [3:0]  o_slot,
    output logic        o_evicted,
    output logic [31:0] o_evicted_key,
    output logic [15:0] o_evicted_frequency
);

    lfu_pkg::t_cmd    cmd;
    lfu_pkg::t_status status;

    lfu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lfu_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_key               (i_key),
        .i_value             (i_value),
        .o_valid             (o_valid),
        .o_hit               (o_hit),
        .o_frequency         (o_frequency),
        .o_value_out         (o_value_out),
        .o_slot              (o_slot),
        .o_evicted           (o_evicted),
        .o_evicted_key       (o_evicted_key),
        .o_evicted_frequency (o_evicted_frequency)
    );

endmodule
